// File: hdl/zrv_pkg.sv
package zrv_pkg;

  // Field widths fixed by the stream format
  localparam int unsigned NUM_LEAFS_W = 13;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned LANES       = 8;
  localparam int unsigned WORD_W      = LANES * BYTE_W;
  localparam int unsigned PACK_W      = (LANES - 1) * BYTE_W;
  localparam int unsigned FILL_W      = 3;
  localparam int unsigned COUNT_W     = 4;

  // Byte written for every position of an all-visible row
  localparam logic [BYTE_W-1:0] ALL_VISIBLE = 8'hff;

  // Input kinds
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_ALL  = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_BUSY
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic step;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic run_empty;
    logic slot_free;
    logic step_ends;
  } sts_t;

endpackage

// File: hdl/zrv_in_if.sv
interface zrv_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;

  modport source (output valid, output kind, output data_byte, input ready);
  modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

// File: hdl/zrv_out_if.sv
interface zrv_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] out_word;
  logic [3:0]  bytes_valid;
  logic        row_done;

  modport source (output valid, output out_word, output bytes_valid, output row_done,
                  input ready);
  modport sink   (input valid, input out_word, input bytes_valid, input row_done,
                  output ready);
endinterface

// File: hdl/zrv_cfg_if.sv
interface zrv_cfg_if;
  logic        valid;
  logic        ready;
  logic [12:0] num_leafs;

  modport source (output valid, output num_leafs, input ready);
  modport sink   (input valid, input num_leafs, output ready);
endinterface

// File: hdl/zero_run_visibility_decoder_core.sv
// Zero-run visibility row decoder.
// in_i carries one compressed transaction: kind 0 with a stream byte, or
// kind 1 to request an all-visible row (data_byte ignored). A nonzero byte
// is a literal; a zero byte is a marker whose following byte expands to that
// many zero bytes, cut at the row end. out_o carries 64-bit words, first byte
// in the low bits, with the count of valid bytes; row_done marks the last
// word of each row of ceil(num_leafs/8) bytes. cfg_i writes num_leafs and is
// always ready; write it only while the decoder is idle.
// Operation: a transaction is taken while the decoder is idle, then worked;
// each work cycle places up to eight bytes (bounded by the free lanes, the
// run and the row end). A word is registered in the work cycle that fills
// it and offered in the next cycle. A finished word waits in the output
// register; while the receiver stalls with it unread, every work cycle
// waits, but a new transaction is still taken once the current one's work
// is done.
// Reset clears the row position, the packing buffer and any pending marker,
// and sets num_leafs to MAX_LEAFS.
module zero_run_visibility_decoder_core #(
  parameter int unsigned MAX_LEAFS = 4096
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  zrv_in_if.sink    in_i,
  zrv_out_if.source out_o,
  zrv_cfg_if.sink   cfg_i
);
  import zrv_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  assign in_i.ready  = in_ready;
  assign cfg_i.ready = 1'b1;

  zrv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  zrv_datapath #(
    .MAX_LEAFS (MAX_LEAFS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .in_kind_i         (in_i.kind),
    .in_byte_i         (in_i.data_byte),
    .cfg_valid_i       (cfg_i.valid),
    .cfg_num_leafs_i   (cfg_i.num_leafs),
    .out_ready_i       (out_o.ready),
    .out_valid_o       (out_o.valid),
    .out_word_o        (out_o.out_word),
    .out_bytes_valid_o (out_o.bytes_valid),
    .out_row_done_o    (out_o.row_done)
  );

endmodule

// File: hdl/zrv_datapath.sv
module zrv_datapath #(
  parameter int unsigned MAX_LEAFS = 4096
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  zrv_pkg::cmd_t                       cmd_i,
  output zrv_pkg::sts_t                       sts_o,
  input  logic                                in_kind_i,
  input  logic [zrv_pkg::BYTE_W-1:0]          in_byte_i,
  input  logic                                cfg_valid_i,
  input  logic [zrv_pkg::NUM_LEAFS_W-1:0]     cfg_num_leafs_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [zrv_pkg::WORD_W-1:0]          out_word_o,
  output logic [zrv_pkg::COUNT_W-1:0]         out_bytes_valid_o,
  output logic                                out_row_done_o
);
  import zrv_pkg::*;

  localparam int unsigned LEN_W = $clog2(MAX_LEAFS / 8 + 1);
  localparam int unsigned RUN_W = (LEN_W > BYTE_W) ? LEN_W : BYTE_W;

  logic [NUM_LEAFS_W-1:0] num_leafs_q;
  logic                   awaiting_q, awaiting_d;
  logic [LEN_W-1:0]       row_cnt_q, row_cnt_d;
  logic [PACK_W-1:0]      pack_q, pack_d;
  logic [FILL_W-1:0]      fill_q, fill_d;
  logic [RUN_W-1:0]       run_q, run_d;
  logic [BYTE_W-1:0]      value_q, value_d;
  logic                   out_valid_q, out_valid_d;
  logic [WORD_W-1:0]      out_word_q, out_word_d;
  logic [COUNT_W-1:0]     out_cnt_q, out_cnt_d;
  logic                   out_done_q, out_done_d;

  logic [NUM_LEAFS_W-1:0] leafs_clamped;
  logic [LEN_W-1:0]       row_len;
  logic [LEN_W-1:0]       row_rem;
  logic [COUNT_W-1:0]     room;
  logic [COUNT_W-1:0]     take;
  logic [COUNT_W-1:0]     new_fill;
  logic [WORD_W-1:0]      word;
  logic                   last;
  logic                   emit;
  logic                   slot_free;

  // Clamp the leaf count and form the row length in bytes
  always_comb begin
    if (num_leafs_q == '0) begin
      leafs_clamped = NUM_LEAFS_W'(1);
    end else if (num_leafs_q > NUM_LEAFS_W'(MAX_LEAFS)) begin
      leafs_clamped = NUM_LEAFS_W'(MAX_LEAFS);
    end else begin
      leafs_clamped = num_leafs_q;
    end
    row_len = LEN_W'(({1'b0, leafs_clamped} + (NUM_LEAFS_W + 1)'(7)) >> 3);
  end

  // Chunk size: bounded by the run, the free lanes and the rest of the row
  always_comb begin
    room    = COUNT_W'(LANES) - {1'b0, fill_q};
    row_rem = (row_cnt_q >= row_len) ? LEN_W'(1) : row_len - row_cnt_q;
    take    = room;
    if (run_q < RUN_W'(take)) begin
      take = 4'(run_q);
    end
    if (RUN_W'(row_rem) < RUN_W'(take)) begin
      take = 4'(row_rem);
    end
    new_fill = {1'b0, fill_q} + take;
    last     = (RUN_W'(row_rem) == RUN_W'(take));
    emit     = new_fill[COUNT_W-1] || last;
  end

  // Place the chunk into its byte lanes
  always_comb begin
    word = {{BYTE_W{1'b0}}, pack_q};
    for (int i = 0; i < LANES; i++) begin
      if ((4'(i) >= {1'b0, fill_q}) && (4'(i) < new_fill)) begin
        word[BYTE_W*i +: BYTE_W] = value_q;
      end
    end
  end

  assign slot_free = !out_valid_q || out_ready_i;

  assign sts_o.run_empty = (run_q == '0);
  assign sts_o.slot_free = slot_free;
  assign sts_o.step_ends = last || (run_q == RUN_W'(take));

  // Next-state logic for the decode state and the output register
  always_comb begin
    awaiting_d  = awaiting_q;
    row_cnt_d   = row_cnt_q;
    pack_d      = pack_q;
    fill_d      = fill_q;
    run_d       = run_q;
    value_d     = value_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_word_d  = out_word_q;
    out_cnt_d   = out_cnt_q;
    out_done_d  = out_done_q;

    if (cmd_i.load) begin
      if (in_kind_i == KIND_ALL) begin
        // Abandon the partial row and start a full row of visible bytes
        awaiting_d = 1'b0;
        row_cnt_d  = '0;
        pack_d     = '0;
        fill_d     = '0;
        run_d      = RUN_W'(row_len);
        value_d    = ALL_VISIBLE;
      end else if (awaiting_q) begin
        awaiting_d = 1'b0;
        run_d      = RUN_W'(in_byte_i);
        value_d    = '0;
      end else if (in_byte_i != '0) begin
        run_d   = RUN_W'(1);
        value_d = in_byte_i;
      end else begin
        awaiting_d = 1'b1;
        run_d      = '0;
      end
    end else if (cmd_i.step) begin
      if (emit) begin
        out_valid_d = 1'b1;
        out_word_d  = word;
        out_cnt_d   = new_fill;
        out_done_d  = last;
        pack_d      = '0;
        fill_d      = '0;
      end else begin
        pack_d = word[PACK_W-1:0];
        fill_d = new_fill[FILL_W-1:0];
      end
      if (last) begin
        // Close the row and drop what is left of the run
        row_cnt_d  = '0;
        awaiting_d = 1'b0;
        run_d      = '0;
      end else begin
        row_cnt_d = row_cnt_q + LEN_W'(take);
        run_d     = run_q - RUN_W'(take);
      end
    end
  end

  // Control and decode state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_leafs_q <= NUM_LEAFS_W'(MAX_LEAFS);
      awaiting_q  <= 1'b0;
      row_cnt_q   <= '0;
      pack_q      <= '0;
      fill_q      <= '0;
      run_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        num_leafs_q <= cfg_num_leafs_i;
      end
      awaiting_q  <= awaiting_d;
      row_cnt_q   <= row_cnt_d;
      pack_q      <= pack_d;
      fill_q      <= fill_d;
      run_q       <= run_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    value_q    <= value_d;
    out_word_q <= out_word_d;
    out_cnt_q  <= out_cnt_d;
    out_done_q <= out_done_d;
  end

  assign out_valid_o       = out_valid_q;
  assign out_word_o        = out_word_q;
  assign out_bytes_valid_o = out_cnt_q;
  assign out_row_done_o    = out_done_q;

endmodule

// File: hdl/zrv_ctrl.sv
module zrv_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  zrv_pkg::sts_t sts_i,
  output zrv_pkg::cmd_t cmd_o
);
  import zrv_pkg::*;

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Take one transaction, then advance its run chunk by chunk
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_BUSY;
        end
      end
      ST_BUSY: begin
        if (sts_i.run_empty) begin
          state_d = ST_IDLE;
        end else if (sts_i.slot_free) begin
          cmd_o.step = 1'b1;
          if (sts_i.step_ends) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// File: dv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import zrv_pkg::*;

  localparam int unsigned MAX_LEAFS = 4096;
  localparam int unsigned ROW_POS_W = 10;
  localparam int unsigned SETTLE    = 8;
  localparam int unsigned HOLD_AT   = 120;
  localparam int unsigned HOLD_LEN  = 400;
  localparam int unsigned STUCK_MAX = 2000;
  localparam int unsigned PHASES    = 13;
  localparam int unsigned PHASE_LEN = 34;
  localparam logic [BYTE_W-1:0] ZERO_MARK = 8'h00;

  typedef struct packed {
    logic [WORD_W-1:0]  word;
    logic [COUNT_W-1:0] nbytes;
    logic               last;
  } vis_word_t;

  // Row rebuild and word comparison
  class vis_row_board;
    logic [NUM_LEAFS_W-1:0] leafs;
    logic [ROW_POS_W-1:0]   row_pos;
    logic [PACK_W-1:0]      pack_buf;
    logic [FILL_W-1:0]      pack_fill;
    bit                     awaiting;
    int unsigned            leaf_cap;
    vis_word_t              words_due[$];
    int unsigned            errors;
    int unsigned            inputs_seen;
    int unsigned            all_vis_seen;
    int unsigned            words_checked;
    int unsigned            rows_closed;
    int unsigned            cfg_writes;

    function new(int unsigned cap);
      leaf_cap  = cap;
      leafs     = NUM_LEAFS_W'(cap);
      row_pos   = '0;
      pack_buf  = '0;
      pack_fill = '0;
      awaiting  = 1'b0;
    endfunction

    function void set_leafs(logic [NUM_LEAFS_W-1:0] v);
      leafs = v;
      cfg_writes++;
    endfunction

    function int unsigned row_len();
      int unsigned n;
      n = leafs;
      if (n < 1) n = 1;
      if (n > leaf_cap) n = leaf_cap;
      return (n + 7) >> 3;
    endfunction

    // Pack one decoded byte; return 1 when it closes the row
    function bit place_byte(logic [BYTE_W-1:0] b);
      logic [WORD_W-1:0]  w;
      logic [COUNT_W-1:0] fill;
      bit                 last;
      vis_word_t          e;
      w = {{BYTE_W{1'b0}}, pack_buf} | ({{(WORD_W-BYTE_W){1'b0}}, b} << (BYTE_W * pack_fill));
      fill = COUNT_W'(pack_fill) + 1'b1;
      row_pos = row_pos + 1'b1;
      last = (row_pos >= row_len());
      if (fill == LANES || last) begin
        e.word   = w;
        e.nbytes = fill;
        e.last   = last;
        words_due.push_back(e);
        pack_buf  = '0;
        pack_fill = '0;
      end else begin
        pack_buf  = w[PACK_W-1:0];
        pack_fill = fill[FILL_W-1:0];
      end
      if (last) begin
        row_pos  = '0;
        awaiting = 1'b0;
      end
      return last;
    endfunction

    // Advance the decoder state for one accepted input transaction
    function void absorb_input(logic k, logic [BYTE_W-1:0] b);
      int unsigned n;
      inputs_seen++;
      if (k == KIND_ALL) begin
        all_vis_seen++;
        awaiting  = 1'b0;
        row_pos   = '0;
        pack_buf  = '0;
        pack_fill = '0;
        n = row_len();
        repeat (n) void'(place_byte(ALL_VISIBLE));
      end else if (awaiting) begin
        awaiting = 1'b0;
        for (int i = 0; i < b; i++) begin
          if (place_byte('0)) break;
        end
      end else if (b != ZERO_MARK) begin
        void'(place_byte(b));
      end else begin
        awaiting = 1'b1;
      end
    endfunction

    // Compare one output transaction with the oldest expected word
    function void check_word(logic [WORD_W-1:0] w, logic [COUNT_W-1:0] n, logic d);
      vis_word_t e;
      words_checked++;
      if (d) rows_closed++;
      if (words_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("[%0t] unexpected word %h bytes %0d row_done %0b", $time, w, n, d);
        return;
      end
      e = words_due.pop_front();
      if (e.word !== w || e.nbytes !== n || e.last !== d) begin
        errors++;
        if (errors <= 10)
          $display("[%0t] word mismatch: exp %h/%0d/%0b got %h/%0d/%0b", $time,
                   e.word, e.nbytes, e.last, w, n, d);
      end
    endfunction

    function int unsigned pending();
      return words_due.size();
    endfunction

    function bit clean();
      if (words_due.size() != 0)
        $display("%0d expected words never arrived", words_due.size());
      return errors == 0 && words_due.size() == 0;
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  bit   quiet;

  zrv_in_if  in_if();
  zrv_out_if out_if();
  zrv_cfg_if cfg_if();

  vis_row_board sb = new(MAX_LEAFS);

  zero_run_visibility_decoder_core #(
    .MAX_LEAFS(MAX_LEAFS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Idle lengths: mostly short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned pick_stall();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  function automatic int unsigned pick_leafs();
    int unsigned r;
    int unsigned corner[8] = '{0, 1, 8, 9, 4095, 4096, 4097, 8191};
    r = $urandom_range(0, 99);
    if (r < 40) return $urandom_range(1, 64);
    if (r < 65) return $urandom_range(65, 600);
    if (r < 80) return $urandom_range(0, 8191);
    return corner[$urandom_range(0, 7)];
  endfunction

  function automatic logic [BYTE_W-1:0] pick_count();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 70) return BYTE_W'($urandom_range(1, 16));
    if (r < 90) return BYTE_W'($urandom_range(17, 64));
    return BYTE_W'($urandom_range(65, 255));
  endfunction

  // Offer one input transaction; keep valid high for a back-to-back item
  task automatic send_item(logic k, logic [BYTE_W-1:0] b);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.kind      <= k;
    in_if.data_byte <= b;
    do @(posedge clk_i); while (!in_if.ready);
    sb.absorb_input(k, b);
  endtask

  task automatic send_run(logic [BYTE_W-1:0] n);
    send_item(KIND_BYTE, ZERO_MARK);
    send_item(KIND_BYTE, n);
  endtask

  // Drop valid, wait for every expected word, then let the block settle
  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_leafs(int unsigned v);
    cfg_if.valid     <= 1'b1;
    cfg_if.num_leafs <= v[NUM_LEAFS_W-1:0];
    do @(posedge clk_i); while (!cfg_if.ready);
    sb.set_leafs(v[NUM_LEAFS_W-1:0]);
    cfg_if.valid <= 1'b0;
  endtask

  // Mostly well-formed rows with random content, some broken sequences and noise
  task automatic random_phase(int unsigned leafs, int unsigned n_items);
    int unsigned sent;
    int unsigned r;
    sent = 0;
    write_leafs(leafs);
    while (sent < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        send_item(KIND_BYTE, BYTE_W'($urandom_range(1, 255)));
        sent += 1;
      end else if (r < 85) begin
        send_run(pick_count());
        sent += 2;
      end else if (r < 90) begin
        send_item(KIND_ALL, BYTE_W'($urandom_range(0, 255)));
        sent += 1;
      end else if (r < 95) begin
        send_item(KIND_BYTE, ZERO_MARK);
        send_item(KIND_ALL, BYTE_W'($urandom_range(0, 255)));
        sent += 2;
      end else begin
        send_item(1'($urandom_range(0, 1)), BYTE_W'($urandom_range(0, 255)));
        sent += 1;
      end
    end
    drain();
  endtask

  // Output side: check words, stall at random, hold off once for a long stretch
  initial begin
    int unsigned stall_left;
    bit          held_once;
    stall_left = 0;
    held_once  = 1'b0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready)
        sb.check_word(out_if.out_word, out_if.bytes_valid, out_if.row_done);
      if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else if (!held_once && sb.inputs_seen >= HOLD_AT) begin
        held_once    = 1'b1;
        stall_left   = HOLD_LEN - 1;
        out_if.ready <= 1'b0;
      end else if (!quiet && rst_ni && $urandom_range(0, 99) < 20) begin
        stall_left   = pick_stall() - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // End the run when no channel moves a transaction for too long
  initial begin
    int unsigned stuck;
    stuck = 0;
    forever begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        stuck = 0;
      else
        stuck++;
      if (stuck >= STUCK_MAX) begin
        $display("[%0t] timeout: no transaction for %0d cycles", $time, stuck);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    in_if.valid      = 1'b0;
    in_if.kind       = KIND_BYTE;
    in_if.data_byte  = '0;
    cfg_if.valid     = 1'b0;
    cfg_if.num_leafs = '0;
    quiet            = 1'b0;
    rst_ni           = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset length: literals at the extremes, zero count, long run,
    // all-visible row over a partial row with a pending marker
    send_item(KIND_BYTE, 8'h01);
    send_item(KIND_BYTE, 8'hff);
    send_run(8'h00);
    send_item(KIND_BYTE, 8'h7f);
    send_run(8'hff);
    send_item(KIND_BYTE, ZERO_MARK);
    send_item(KIND_ALL, 8'haa);
    drain();

    // Lower the row length under a partial row, then overshoot with a run
    write_leafs(64);
    for (int i = 0; i < 5; i++) send_item(KIND_BYTE, BYTE_W'(i + 'h11));
    drain();
    write_leafs(9);
    send_item(KIND_BYTE, 8'h16);
    send_run(8'd200);
    send_item(KIND_BYTE, 8'h42);
    drain();

    // Leaf count clamped up to one byte
    write_leafs(0);
    send_item(KIND_BYTE, 8'hfe);
    send_run(8'd3);
    send_item(KIND_ALL, 8'h00);
    drain();

    // Leaf count clamped down to the largest row
    write_leafs(8191);
    send_item(KIND_ALL, 8'hff);
    drain();
    write_leafs(4097);
    send_run(8'hff);
    drain();

    // Random phases; two run without any idling
    for (int p = 0; p < PHASES; p++) begin
      quiet = (p == 4 || p == 9);
      if (p == 0)
        random_phase(MAX_LEAFS, PHASE_LEN);
      else if (p == 1)
        random_phase(1, PHASE_LEN);
      else
        random_phase(pick_leafs(), PHASE_LEN);
    end
    quiet = 1'b0;
    drain();

    $display("Covered %0d input transactions (%0d all-visible) over %0d leaf-count writes",
             sb.inputs_seen, sb.all_vis_seen, sb.cfg_writes);
    $display("Compared %0d output words closing %0d rows", sb.words_checked, sb.rows_closed);
    if (sb.clean())
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
